/* rtl/core/granular_pitch_shifter_assert.svh */
// Assertion macros for the pitch shifter core.
// Expects clk_i and rst_ni in the including module.
`ifndef GRANULAR_PITCH_SHIFTER_ASSERT_SVH
`define GRANULAR_PITCH_SHIFTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define GPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/gps_pkg.sv */
// Shared types and constants of the granular pitch shifter.
// No dependencies.
package gps_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX   = 2'd2;

  localparam logic [15:0] STEP_UNITY = 16'd16384;
  localparam logic [15:0] BYPASS_TOL = 16'd9;
  localparam logic [16:0] WET_FULL   = 17'd32768;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

endpackage

/* rtl/core/granular_pitch_shifter.sv */
// Granular overlap-add pitch shifter, top level and only module.
// Depends on gps_pkg and granular_pitch_shifter_assert.svh.
//
// One stereo frame per transaction. After reset the delay memory is cleared, one
// row a cycle, with in_stall_o high. Bypassed frames go from the write state
// straight to the output; otherwise the grain sequencer walks the slots, and
// each live grain needs two reads of the single read port of the delay memory,
// an interpolation and a multiply-accumulate. Both channels share one memory
// word and one grain set, so they run side by side. A finished frame waits in
// the output register while the next frame is taken in.
// BUFFER_DEPTH and GRAIN_LENGTH must be powers of two.
module granular_pitch_shifter #(
  parameter int unsigned BUFFER_DEPTH = 16384,
  parameter int unsigned GRAIN_LENGTH = 1024,
  parameter int unsigned HOP_LENGTH   = 256,
  parameter int unsigned GRAIN_SLOTS  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gps_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gps_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AB   = $clog2(BUFFER_DEPTH);
  localparam int unsigned LB   = $clog2(GRAIN_LENGTH);
  localparam int unsigned HB   = (HOP_LENGTH > 1) ? $clog2(HOP_LENGTH) : 1;
  localparam int unsigned SLW  = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;
  localparam int unsigned PW   = 2 * LB + 16;
  localparam int unsigned ACCW = 34 + SLW;
  localparam int unsigned TW   = ACCW + 20;
  localparam int unsigned SPAWN_BACK = (2 * GRAIN_LENGTH) % BUFFER_DEPTH;

  typedef logic [16:0] hann_arr_t [GRAIN_LENGTH];

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_WRITE  = 10'b0000000100,
    S_MUL    = 10'b0000001000,
    S_RD0    = 10'b0000010000,
    S_RD1    = 10'b0000100000,
    S_INTERP = 10'b0001000000,
    S_ACC    = 10'b0010000000,
    S_MIX    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_e;

  // Hann window, Q15, built at elaboration with a truncating Taylor sine.
  function automatic hann_arr_t build_hann();
    hann_arr_t t;
    longint unsigned m, x, x2, r, s, w, v;
    for (int i = 0; i < GRAIN_LENGTH; i++) begin
      m = (i < GRAIN_LENGTH - 1 - i) ? longint'(i) : longint'(GRAIN_LENGTH - 1 - i);
      x  = (gps_pkg::PI_Q30 * m) / (GRAIN_LENGTH - 1);
      x2 = (x * x) >> 30;
      r  = gps_pkg::Q30_ONE - x2 / 110;
      r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 72;
      r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 42;
      r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 20;
      r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 6;
      s  = (x * r) >> 30;
      w  = (s * s) >> 30;
      v  = (w * 32768 + 64'd536870912) >> 30;
      t[i] = (v > 32768) ? 17'd32768 : v[16:0];
    end
    return t;
  endfunction

  localparam hann_arr_t HANN_ROM = build_hann();

  function automatic logic signed [15:0] sat16(input logic signed [TW-1:0] v);
    if (v > TW'(32767)) begin
      return 16'sh7fff;
    end else if (v < -TW'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  state_e state_q, state_d;

  // configuration
  logic        en_q;
  logic [15:0] step_q, wet_q;

  // frame context
  logic signed [15:0] xl_q, xr_q;
  logic               bypass_q;
  logic [AB-1:0]      wi_q, clr_q;
  logic [HB-1:0]      hop_q;
  logic [SLW-1:0]     slot_q;

  // grain set, shared by both channels
  logic          live_q  [GRAIN_SLOTS];
  logic [LB-1:0] count_q [GRAIN_SLOTS];
  logic [AB-1:0] start_q [GRAIN_SLOTS];

  // delay memory, word is {left, right}
  logic [31:0]   mem [BUFFER_DEPTH];
  logic          mem_we;
  logic [AB-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata_q, s0_q;

  // grain datapath
  logic [PW-1:0]      prod_q;
  logic [AB-1:0]      ip0_q, ip0;
  logic [16:0]        win_q;
  logic signed [15:0] smp_l_q, smp_r_q;
  logic signed [ACCW-1:0] acc_l_q, acc_r_q;
  logic signed [ACCW+17:0] wetp_l_q, wetp_r_q;
  logic signed [33:0] dry_l_q, dry_r_q;

  logic               out_valid_q;
  gps_pkg::out_t      out_data_q;

  logic [LB-1:0]      k;
  logic [2*LB-1:0]    kmul;
  logic [LB-1:0]      widx;
  logic [AB+LB+2:0]   ip_sum;
  logic [13:0]        frac;
  logic               last_slot, out_busy, bypass_now;
  logic [16:0]        wm;
  logic signed [15:0] sm_l, sm_r;
  logic signed [TW-1:0] tot_l, tot_r;
  logic [SLW-1:0]     free_slot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign out_busy  = out_valid_q && out_stall_i;
  assign last_slot = (slot_q == SLW'(GRAIN_SLOTS - 1));

  // age k maps to window index floor(k*(L-1)/L) = k-1, and 0 at k = 0
  assign k    = count_q[slot_q];
  assign kmul = {k, {LB{1'b0}}} - (2*LB)'(k);
  assign widx = (k == '0) ? '0 : k - LB'(1);

  // integer offset sits above the 14 fraction bits of prod >> LB
  assign ip_sum = (AB+LB+3)'(start_q[slot_q]) + (AB+LB+3)'(prod_q[PW-1:LB+14]);
  assign ip0    = ip_sum[AB-1:0];
  assign frac   = prod_q[LB+13:LB];

  assign bypass_now = !en_q ||
                      ((step_q >= gps_pkg::STEP_UNITY - gps_pkg::BYPASS_TOL) &&
                       (step_q <= gps_pkg::STEP_UNITY + gps_pkg::BYPASS_TOL));

  assign wm = (wet_q > gps_pkg::WET_FULL[15:0] || wet_q[15]) ? gps_pkg::WET_FULL
                                                              : {1'b0, wet_q};

  always_comb begin
    logic signed [16:0] dl, dr;
    logic signed [32:0] il, ir;
    dl = 17'(signed'(rdata_q[31:16])) - 17'(signed'(s0_q[31:16]));
    dr = 17'(signed'(rdata_q[15:0])) - 17'(signed'(s0_q[15:0]));
    il = (33'(signed'(s0_q[31:16])) <<< 14) + 33'(dl * signed'({1'b0, frac}));
    ir = (33'(signed'(s0_q[15:0])) <<< 14) + 33'(dr * signed'({1'b0, frac}));
    sm_l = il[29:14];
    sm_r = ir[29:14];
  end

  always_comb begin
    tot_l = TW'(wetp_l_q) + (TW'(dry_l_q) <<< 15) + TW'(32'sd536870912);
    tot_r = TW'(wetp_r_q) + (TW'(dry_r_q) <<< 15) + TW'(32'sd536870912);
    tot_l = tot_l >>> 30;
    tot_r = tot_r >>> 30;
  end

  // first free slot after this frame's updates, slot 0 when all are busy
  always_comb begin
    free_slot = '0;
    for (int g = GRAIN_SLOTS - 1; g >= 0; g--) begin
      if (!live_q[g]) begin
        free_slot = SLW'(g);
      end
    end
  end

  always_comb begin
    mem_we = (state_q == S_CLEAR) || (state_q == S_WRITE);
    waddr  = (state_q == S_CLEAR) ? clr_q : wi_q;
    wdata  = (state_q == S_CLEAR) ? '0 : {xl_q, xr_q};
    raddr  = (state_q == S_RD1) ? ip0_q + AB'(1) : ip0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == AB'(BUFFER_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_WRITE;
      S_WRITE:  state_d = bypass_now ? S_FIN : S_MUL;
      S_MUL: begin
        if (live_q[slot_q]) begin
          state_d = S_RD0;
        end else if (last_slot) begin
          state_d = S_MIX;
        end
      end
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_INTERP;
      S_INTERP: state_d = S_ACC;
      S_ACC:    state_d = last_slot ? S_MIX : S_MUL;
      S_MIX:    state_d = S_FIN;
      S_FIN:    if (!out_busy) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wi_q        <= '0;
      hop_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      en_q        <= 1'b0;
      step_q      <= gps_pkg::STEP_UNITY;
      wet_q       <= gps_pkg::WET_FULL[15:0];
      for (int g = 0; g < GRAIN_SLOTS; g++) begin
        live_q[g] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gps_pkg::CFG_EFFECT_ON: en_q   <= cfg_data_i[0];
          gps_pkg::CFG_READ_STEP: step_q <= cfg_data_i;
          gps_pkg::CFG_WET_MIX:   wet_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AB'(1);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_WRITE: slot_q <= '0;
        S_MUL: begin
          if (!live_q[slot_q] && !last_slot) begin
            slot_q <= slot_q + SLW'(1);
          end
        end
        S_ACC: begin
          // retire at the end of the window, else age by one frame
          if (k == LB'(GRAIN_LENGTH - 1)) begin
            live_q[slot_q] <= 1'b0;
          end
          if (!last_slot) begin
            slot_q <= slot_q + SLW'(1);
          end
        end
        S_MIX: begin
          if (hop_q == '0) begin
            live_q[free_slot] <= 1'b1;
          end
        end
        S_FIN: begin
          if (!out_busy) begin
            out_valid_q <= 1'b1;
            wi_q        <= wi_q + AB'(1);
            hop_q       <= (hop_q == HB'(HOP_LENGTH - 1)) ? '0 : hop_q + HB'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        xl_q <= in_data_i.left_sample;
        xr_q <= in_data_i.right_sample;
      end
      S_WRITE: begin
        bypass_q <= bypass_now;
        acc_l_q  <= '0;
        acc_r_q  <= '0;
      end
      S_MUL:    prod_q <= PW'(kmul * step_q);
      S_RD0: begin
        ip0_q <= ip0;
        win_q <= HANN_ROM[widx];
      end
      S_RD1:    s0_q <= rdata_q;
      S_INTERP: begin
        smp_l_q <= sm_l;
        smp_r_q <= sm_r;
      end
      S_ACC: begin
        acc_l_q <= acc_l_q + ACCW'(smp_l_q * signed'({1'b0, win_q}));
        acc_r_q <= acc_r_q + ACCW'(smp_r_q * signed'({1'b0, win_q}));
        count_q[slot_q] <= (k == LB'(GRAIN_LENGTH - 1)) ? '0 : k + LB'(1);
      end
      S_MIX: begin
        wetp_l_q <= (ACCW+18)'(acc_l_q * signed'({1'b0, wm}));
        wetp_r_q <= (ACCW+18)'(acc_r_q * signed'({1'b0, wm}));
        dry_l_q  <= 34'(xl_q * signed'({1'b0, gps_pkg::WET_FULL - wm}));
        dry_r_q  <= 34'(xr_q * signed'({1'b0, gps_pkg::WET_FULL - wm}));
        if (hop_q == '0) begin
          count_q[free_slot] <= '0;
          start_q[free_slot] <= wi_q - AB'(SPAWN_BACK);
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          out_data_q.left_out  <= bypass_q ? xl_q : sat16(tot_l);
          out_data_q.right_out <= bypass_q ? xr_q : sat16(tot_r);
        end
      end
      default: ;
    endcase
  end

`include "granular_pitch_shifter_assert.svh"

  `GPS_ASSERT_ALWAYS(a_ready_only_idle, !in_stall_o |-> state_q == S_IDLE, "input taken outside idle")
  `GPS_ASSERT(a_accept_writes, (in_valid_i && !in_stall_o) |=> state_q == S_WRITE, "accepted frame not written")
  `GPS_ASSERT(a_no_result_in_clear, state_q == S_CLEAR |-> !out_valid_o, "result during clearing pass")
  `GPS_ASSERT(a_wi_advance, (state_q == S_FIN && !out_busy) |=> wi_q == $past(wi_q) + AB'(1), "write index not advanced")

endmodule

/* verif/gps_frame_checker.sv */
// Frame checker of the granular pitch shifter: watches the three channels,
// predicts every output frame and compares it with what the block returns.
// Depends on gps_pkg.
module gps_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  gps_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  gps_pkg::out_t                  out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             frames_owed_o
);

  localparam int unsigned DEPTH = 16384;
  localparam int unsigned GLEN  = 1024;
  localparam int unsigned HOP   = 256;
  localparam int unsigned SLOTS = 4;

  logic signed [15:0] delay_mem [2][DEPTH];
  logic [15:0]        window    [GLEN];
  bit                 grain_on  [2][SLOTS];
  int unsigned        grain_age [2][SLOTS];
  int unsigned        grain_pos [2][SLOTS];
  int unsigned        wr_ptr;
  int unsigned        hop_ctr;
  bit                 shift_en;
  logic [15:0]        step_q14;
  logic [15:0]        wet_q15;
  gps_pkg::out_t      expected_frames [$];
  int                 fails;

  assign fail_count_o  = fails;
  assign frames_owed_o = expected_frames.size();

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, r;
    x2 = (x * x) >> 30;
    r  = gps_pkg::Q30_ONE - x2 / 110;
    r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 72;
    r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 42;
    r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 20;
    r  = gps_pkg::Q30_ONE - ((x2 * r) >> 30) / 6;
    return (x * r) >> 30;
  endfunction

  task automatic clear_model();
    longint unsigned m, s, w, v;
    for (int i = 0; i < GLEN; i++) begin
      m = (i < GLEN - 1 - i) ? i : GLEN - 1 - i;
      s = sine_q30((gps_pkg::PI_Q30 * m) / (GLEN - 1));
      w = (s * s) >> 30;
      v = (w * 32768 + (64'd1 << 29)) >> 30;
      window[i] = (v > 32768) ? 16'd32768 : v[15:0];
    end
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < DEPTH; i++) delay_mem[c][i] = '0;
      for (int g = 0; g < SLOTS; g++) begin
        grain_on[c][g]  = 1'b0;
        grain_age[c][g] = 0;
        grain_pos[c][g] = 0;
      end
    end
    wr_ptr   = 0;
    hop_ctr  = 0;
    shift_en = 1'b0;
    step_q14 = gps_pkg::STEP_UNITY;
    wet_q15  = 16'd32768;
    expected_frames.delete();
  endtask

  // Render one channel of one frame and advance its grains.
  function automatic logic signed [15:0] shift_channel(int ch, longint x, bit thru);
    longint acc, off, s0, s1, smp, wm, total, res;
    int unsigned k, widx, ip0, ip1, slot;
    delay_mem[ch][wr_ptr] = x[15:0];
    if (thru) return x[15:0];
    acc = 0;
    for (int g = 0; g < SLOTS; g++) begin
      if (grain_on[ch][g]) begin
        k    = grain_age[ch][g] % GLEN;
        widx = (k * (GLEN - 1)) / GLEN;
        off  = (longint'(k) * (GLEN - 1) * longint'(step_q14)) / GLEN;
        ip0  = (grain_pos[ch][g] + int'(off >> 14)) % DEPTH;
        ip1  = (ip0 + 1) % DEPTH;
        s0   = delay_mem[ch][ip0];
        s1   = delay_mem[ch][ip1];
        // keep the sum signed so the shift floors
        smp  = (s0 * 16384 + (s1 - s0) * longint'(off & 64'h3FFF)) >>> 14;
        acc += smp * longint'(window[widx]);
        k++;
        if (k >= GLEN) begin
          grain_on[ch][g] = 1'b0;
          k = 0;
        end
        grain_age[ch][g] = k;
      end
    end
    // new grain in the first free slot, otherwise restart slot zero
    if (hop_ctr == 0) begin
      slot = 0;
      for (int g = SLOTS - 1; g >= 0; g--) if (!grain_on[ch][g]) slot = g;
      grain_on[ch][slot]  = 1'b1;
      grain_age[ch][slot] = 0;
      grain_pos[ch][slot] = (wr_ptr + DEPTH - (2 * GLEN) % DEPTH) % DEPTH;
    end
    wm    = (wet_q15 > 16'd32768) ? 32768 : longint'(wet_q15);
    total = acc * wm + x * (32768 - wm) * 32768;
    res   = (total + (64'sd1 <<< 29)) >>> 30;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  function automatic gps_pkg::out_t predict_frame(gps_pkg::in_t f);
    gps_pkg::out_t o;
    int unsigned dev;
    bit thru;
    dev  = (step_q14 > gps_pkg::STEP_UNITY) ? step_q14 - gps_pkg::STEP_UNITY
                                            : gps_pkg::STEP_UNITY - step_q14;
    thru = !shift_en || (dev <= gps_pkg::BYPASS_TOL);
    o.left_out  = shift_channel(0, longint'(f.left_sample), thru);
    o.right_out = shift_channel(1, longint'(f.right_sample), thru);
    wr_ptr  = (wr_ptr + 1) % DEPTH;
    hop_ctr = (hop_ctr + 1) % HOP;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gps_pkg::CFG_EFFECT_ON: shift_en = cfg_data_i[0];
          gps_pkg::CFG_READ_STEP: step_q14 = cfg_data_i;
          gps_pkg::CFG_WET_MIX:   wet_q15  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected frame", 1, 0);
        end else begin
          gps_pkg::out_t want;
          want = expected_frames.pop_front();
          if (out_data_i.left_out !== want.left_out)
            report_mismatch("left_out", out_data_i.left_out, want.left_out);
          if (out_data_i.right_out !== want.right_out)
            report_mismatch("right_out", out_data_i.right_out, want.right_out);
        end
      end
      if (in_valid_i && !in_stall_i) expected_frames.push_back(predict_frame(in_data_i));
    end
  end

endmodule

/* verif/granular_pitch_shifter_tb.sv */
// Testbench top of the granular pitch shifter: clock, reset, frame and
// register stimulus, and the verdict. Depends on gps_pkg, gps_frame_checker and granular_pitch_shifter.
module granular_pitch_shifter_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_FRAMES = 255;
  localparam int HOLDOFF_LEN  = 400;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  gps_pkg::in_t                   in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  gps_pkg::out_t                  out_data_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int frames_owed;
  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_asked;
  int holdoff_served;
  int holdoff_left;
  int cycle_count;

  granular_pitch_shifter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  gps_frame_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .frames_owed_o (frames_owed)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Abort the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off once asked for, so the
  // block fills up and pushes back on its input.
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i = 1'b1;
      holdoff_left--;
    end else if (holdoff_asked > holdoff_served) begin
      holdoff_served++;
      holdoff_left = HOLDOFF_LEN;
      out_stall_i  = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one frame; hold it until the block takes the transaction.
  task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i             = 1'b1;
    in_data_i.left_sample  = l;
    in_data_i.right_sample = r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Pause the sender until every predicted frame has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (frames_owed != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [gps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly full-range random samples, now and then an extreme.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    cycle_count    = 0;
    holdoff_asked  = 0;
    holdoff_served = 0;
    holdoff_left   = 0;
    send_idle_pct  = 30;
    recv_idle_pct  = 76;
    out_stall_i    = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = gps_pkg::CFG_EFFECT_ON;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: effect off, frames come straight back.
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hAAAA, 16'h5555);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'h8000, 16'h8000);
    drain();

    // Step just inside the unity tolerance on both sides still bypasses.
    write_reg(gps_pkg::CFG_EFFECT_ON, 16'h0001);
    write_reg(gps_pkg::CFG_READ_STEP, gps_pkg::STEP_UNITY + gps_pkg::BYPASS_TOL);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h1234, 16'hEDCB);
    drain();
    write_reg(gps_pkg::CFG_READ_STEP, gps_pkg::STEP_UNITY - gps_pkg::BYPASS_TOL);
    send_frame(16'h8001, 16'h0001);
    send_frame(16'hFFFF, 16'h0000);
    drain();

    // Just outside the tolerance, wet above range, unused index, stray high bits.
    write_reg(gps_pkg::CFG_READ_STEP, gps_pkg::STEP_UNITY + gps_pkg::BYPASS_TOL + 16'd1);
    write_reg(gps_pkg::CFG_WET_MIX, 16'hFFFF);
    write_reg(2'd3, 16'hFFFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h4000, 16'hC000);
    drain();
    write_reg(gps_pkg::CFG_EFFECT_ON, 16'hFFFE);
    send_frame(16'h7FFF, 16'h8000);
    drain();
    write_reg(gps_pkg::CFG_EFFECT_ON, 16'h0001);
    send_frame(16'h8000, 16'h7FFF);
    drain();

    // Random phases, each with its own settings; the idling pattern changes every two phases.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(gps_pkg::CFG_READ_STEP, 16'd32768);
          write_reg(gps_pkg::CFG_WET_MIX, 16'd32768);
        end
        1: begin
          write_reg(gps_pkg::CFG_READ_STEP, 16'd8192);
          write_reg(gps_pkg::CFG_WET_MIX, 16'hFFFF);
        end
        2: begin
          write_reg(gps_pkg::CFG_READ_STEP, 16'($urandom_range(8192, 32768)));
          write_reg(gps_pkg::CFG_WET_MIX, 16'($urandom_range(0, 32768)));
        end
        3: begin
          write_reg(gps_pkg::CFG_READ_STEP,
                    gps_pkg::STEP_UNITY + gps_pkg::BYPASS_TOL + 16'd1);
          write_reg(gps_pkg::CFG_WET_MIX, 16'd0);
        end
        4: begin
          write_reg(gps_pkg::CFG_EFFECT_ON, 16'h0000);
          write_reg(gps_pkg::CFG_READ_STEP, 16'($urandom_range(8192, 32768)));
        end
        default: begin
          write_reg(gps_pkg::CFG_EFFECT_ON, 16'h0001);
          write_reg(gps_pkg::CFG_READ_STEP, 16'($urandom_range(8192, 32768)));
          write_reg(gps_pkg::CFG_WET_MIX, 16'd16384);
        end
      endcase
      send_idle_pct = (p < 2) ? 30 : (p < 4) ? 76 : 0;
      recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 30 : 0;
      // hold the receiver off while the sender keeps going
      if (p == 4) holdoff_asked++;
      for (int n = 0; n < PHASE_FRAMES; n++) send_frame(pick_sample(), pick_sample());
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && frames_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
